@@ src/slms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package slms_pkg;

    // Fixed geometry of one shift-register byte on the wire
    localparam int BYTE_BITS = 8;
    localparam int BYTE_SPAN = 2 * BYTE_BITS + 2;   // bits plus latch pulse
    localparam int ROW_SPAN  = 2 * BYTE_SPAN;       // row byte then column byte
    localparam int PHASE_W   = 6;
    localparam int BPHASE_W  = 5;
    localparam int BIT_W     = 3;

    // Field widths
    localparam int TYPE_W    = 2;
    localparam int RIDX_W    = 3;
    localparam int CONTENT_W = 64;
    localparam int OFFSET_W  = 6;
    localparam int DWELL_W   = 24;
    localparam int PIN_W     = 6;

    // Pin positions in the pin level vector
    localparam logic [2:0] PIN_RDATA  = 3'd0;
    localparam logic [2:0] PIN_RSHIFT = 3'd1;
    localparam logic [2:0] PIN_RLATCH = 3'd2;
    localparam logic [2:0] PIN_CDATA  = 3'd3;

    localparam logic [DWELL_W-1:0]  DWELL_MAX   = 24'hFFFFFF;
    localparam logic [DWELL_W-1:0]  DWELL_RESET = 24'd3200000;
    localparam logic [OFFSET_W-1:0] STEPS_RESET = 6'd56;

    // APB register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_AUTO  = 2'd0;
    localparam logic [1:0] REG_DWELL = 2'd1;
    localparam logic [1:0] REG_STEPS = 2'd2;

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_WRITE  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_OFFSET = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0]    req_type;
        logic [RIDX_W-1:0]    row_index;
        logic [CONTENT_W-1:0] row_bits;
        logic [OFFSET_W-1:0]  offset_value;
    } req_t;

    typedef struct packed {
        logic [PIN_W-1:0]    pins;
        logic                frame_done;
        logic [OFFSET_W-1:0] current_offset;
    } res_t;

    typedef struct packed {
        logic                auto_scroll;
        logic [DWELL_W-1:0]  dwell_ticks;
        logic [OFFSET_W-1:0] scroll_steps;
    } cfg_t;

endpackage

`default_nettype wire

@@ src/slms_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface slms_req_if;
    logic                            valid;
    logic                            ready;
    logic [slms_pkg::TYPE_W-1:0]     req_type;
    logic [slms_pkg::RIDX_W-1:0]     row_index;
    logic [slms_pkg::CONTENT_W-1:0]  row_bits;
    logic [slms_pkg::OFFSET_W-1:0]   offset_value;

    modport source (output valid, output req_type, output row_index, output row_bits,
                    output offset_value, input ready);
    modport sink   (input valid, input req_type, input row_index, input row_bits,
                    input offset_value, output ready);
endinterface

interface slms_res_if;
    logic                           valid;
    logic                           ready;
    logic                           row_data_pin;
    logic                           row_shift_pin;
    logic                           row_latch_pin;
    logic                           col_data_pin;
    logic                           col_shift_pin;
    logic                           col_latch_pin;
    logic                           frame_done;
    logic [slms_pkg::OFFSET_W-1:0]  current_offset;

    modport source (output valid, output row_data_pin, output row_shift_pin,
                    output row_latch_pin, output col_data_pin, output col_shift_pin,
                    output col_latch_pin, output frame_done, output current_offset,
                    input ready);
    modport sink   (input valid, input row_data_pin, input row_shift_pin,
                    input row_latch_pin, input col_data_pin, input col_shift_pin,
                    input col_latch_pin, input frame_done, input current_offset,
                    output ready);
endinterface

`default_nettype wire

@@ src/shift_register_led_matrix_scanner_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// LED matrix scanner for two chained-style serial shift registers (row, column).
// Request channel (req): valid/ready with req_type, row_index, row_bits,
// offset_value. A tick request moves the six pins one step; a write request
// loads a row of pixel content; an offset request sets the scroll position.
// Response channel (res): valid/ready, one response per request, carrying the
// six pin levels, frame_done and the offset in use on that request.
// Every row takes 36 ticks (18 for the row byte, 18 for the column byte) and a
// frame takes 36 * MATRIX_ROWS ticks.
// A request accepted is held in the input register, worked through the scan
// logic and its response is held in the result register until it is taken.
// Throughput: one request per clock when not stalled, set by the single
// register-to-register pass through the scan logic (row mux, window select, phase counter).
// Reset: row store cleared, pins low, scroll offset, dwell count, row and
// phase zero, registers at their documented defaults.
// Stall: when res.ready is low the response holds, the input register holds
// one more request and req.ready drops until the response is taken.
// Configuration (APB, regs at 0x0 auto_scroll, 0x4 dwell_ticks, 0x8 scroll_steps)
// is to be written by the user while the block is idle; the block does not enforce it.

module shift_register_led_matrix_scanner_core
#(
    parameter int MATRIX_ROWS  = 8,
    parameter int CONTENT_BITS = 64
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    slms_req_if.sink                               req,
    slms_res_if.source                             res,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [slms_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [slms_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [slms_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    localparam logic [slms_pkg::OFFSET_W-1:0] MAX_OFFSET =
        slms_pkg::OFFSET_W'(CONTENT_BITS - slms_pkg::BYTE_BITS);

    slms_pkg::cfg_t  cfg;
    slms_pkg::req_t  in_req_reg;
    logic            in_valid_reg;
    slms_pkg::res_t  eng_res;
    slms_pkg::res_t  out_reg;
    logic            out_valid_reg;
    logic            adv;      // result register can take a new value
    logic            go;       // input register is worked this cycle
    logic            in_take;

    assign adv       = !out_valid_reg || res.ready;
    assign go        = in_valid_reg && adv;
    assign req.ready = !in_valid_reg || adv;
    assign in_take   = req.valid && req.ready;

    slms_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slms_engine
    #(
        .MATRIX_ROWS  (MATRIX_ROWS),
        .CONTENT_BITS (CONTENT_BITS)
    )
    u_engine
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .req   (in_req_reg),
        .cfg   (cfg),
        .res   (eng_res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (adv)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_req_reg.req_type     <= req.req_type;
            in_req_reg.row_index    <= req.row_index;
            in_req_reg.row_bits     <= req.row_bits;
            in_req_reg.offset_value <= req.offset_value;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (go)
            out_reg <= eng_res;
    end

    assign res.valid          = out_valid_reg;
    assign res.row_data_pin   = out_reg.pins[0];
    assign res.row_shift_pin  = out_reg.pins[1];
    assign res.row_latch_pin  = out_reg.pins[2];
    assign res.col_data_pin   = out_reg.pins[3];
    assign res.col_shift_pin  = out_reg.pins[4];
    assign res.col_latch_pin  = out_reg.pins[5];
    assign res.frame_done     = out_reg.frame_done;
    assign res.current_offset = out_reg.current_offset;

    // A held request is never dropped while the response side stalls
    a_hold_stalled_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !adv) |=> in_valid_reg)
        else $error("input register lost a stalled request");

    // Offset in use never leaves the legal scroll range
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.current_offset <= MAX_OFFSET))
        else $error("current_offset beyond last scroll step");

    // Frame end is the falling half of the column latch pulse
    a_frame_end_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.frame_done) |-> (!res.col_latch_pin && !res.col_shift_pin))
        else $error("frame_done outside the column latch release");

    // Responses only follow worked requests
    a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !in_valid_reg) |=> !out_valid_reg)
        else $error("response without a request");

endmodule

`default_nettype wire

@@ src/slms_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slms_cfg
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [slms_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [slms_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [slms_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output slms_pkg::cfg_t                         cfg
);

    slms_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_scroll  <= 1'b0;
            cfg_reg.dwell_ticks  <= slms_pkg::DWELL_RESET;
            cfg_reg.scroll_steps <= slms_pkg::STEPS_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                slms_pkg::REG_AUTO:  cfg_reg.auto_scroll  <= pwdata[0];
                slms_pkg::REG_DWELL: cfg_reg.dwell_ticks  <= pwdata[slms_pkg::DWELL_W-1:0];
                slms_pkg::REG_STEPS: cfg_reg.scroll_steps <= pwdata[slms_pkg::OFFSET_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            slms_pkg::REG_AUTO:  prdata = 32'(cfg_reg.auto_scroll);
            slms_pkg::REG_DWELL: prdata = 32'(cfg_reg.dwell_ticks);
            slms_pkg::REG_STEPS: prdata = 32'(cfg_reg.scroll_steps);
            default:             prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/slms_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slms_engine
#(
    parameter int MATRIX_ROWS  = 8,
    parameter int CONTENT_BITS = 64
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           go,
    input  slms_pkg::req_t      req,
    input  slms_pkg::cfg_t      cfg,
    output slms_pkg::res_t      res
);

    localparam int ROW_W = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;
    localparam logic [slms_pkg::OFFSET_W-1:0] MAX_OFFSET =
        slms_pkg::OFFSET_W'(CONTENT_BITS - slms_pkg::BYTE_BITS);

    logic [CONTENT_BITS-1:0]              rows_reg [MATRIX_ROWS];
    logic [slms_pkg::OFFSET_W-1:0]        offset_reg, offset_next;
    logic [slms_pkg::DWELL_W-1:0]         dwell_reg, dwell_next;
    logic [ROW_W-1:0]                     scan_row_reg, scan_row_next;
    logic [slms_pkg::PHASE_W-1:0]         phase_reg, phase_next;
    logic [slms_pkg::PIN_W-1:0]           pins_reg, pins_next;

    logic                                 wr_en;
    logic [ROW_W-1:0]                     wr_idx;
    logic                                 in_col;
    logic [slms_pkg::BPHASE_W-1:0]        bphase;
    logic [slms_pkg::BIT_W-1:0]           msb_idx;
    logic [slms_pkg::OFFSET_W:0]          win_idx;
    logic [63:0]                          row_word;
    logic                                 row_bit;
    logic                                 col_bit;
    logic                                 data_bit;
    logic [2:0]                           pin_dat, pin_shf, pin_lat;
    logic [slms_pkg::DWELL_W-1:0]         need;
    logic                                 frame_end;

    // Bit currently on the wire: row byte is one-hot, column byte is the
    // inverted window of the scanned row at the scroll offset, MSB first.
    assign in_col   = (phase_reg >= slms_pkg::PHASE_W'(slms_pkg::BYTE_SPAN));
    assign bphase   = in_col ? slms_pkg::BPHASE_W'(phase_reg - slms_pkg::PHASE_W'(slms_pkg::BYTE_SPAN))
                             : phase_reg[slms_pkg::BPHASE_W-1:0];
    assign msb_idx  = ~bphase[slms_pkg::BIT_W:1];
    assign row_bit  = (5'(scan_row_reg) == 5'(msb_idx));
    assign row_word = 64'(rows_reg[scan_row_reg]);
    assign win_idx  = {1'b0, offset_reg} + (slms_pkg::OFFSET_W+1)'(msb_idx);
    assign col_bit  = ~(win_idx[slms_pkg::OFFSET_W] ? 1'b0
                                                    : row_word[win_idx[slms_pkg::OFFSET_W-1:0]]);
    assign data_bit = in_col ? col_bit : row_bit;
    assign pin_dat  = in_col ? slms_pkg::PIN_CDATA : slms_pkg::PIN_RDATA;
    assign pin_shf  = pin_dat + 3'd1;
    assign pin_lat  = pin_dat + 3'd2;

    assign need      = (cfg.dwell_ticks == '0) ? slms_pkg::DWELL_W'(1) : cfg.dwell_ticks;
    assign frame_end = (phase_reg == slms_pkg::PHASE_W'(slms_pkg::ROW_SPAN - 1)) &&
                       (scan_row_reg == ROW_W'(MATRIX_ROWS - 1));

    assign wr_en  = go && (req.req_type == slms_pkg::REQ_WRITE) &&
                    (5'(req.row_index) < 5'(MATRIX_ROWS));
    assign wr_idx = ROW_W'(req.row_index);

    always_comb
    begin
        offset_next        = offset_reg;
        dwell_next         = dwell_reg;
        scan_row_next      = scan_row_reg;
        phase_next         = phase_reg;
        pins_next          = pins_reg;
        res.frame_done     = 1'b0;
        res.current_offset = offset_reg;

        if (go)
        begin
            case (req.req_type)
                slms_pkg::REQ_OFFSET:
                begin
                    offset_next        = (req.offset_value > MAX_OFFSET) ? MAX_OFFSET
                                                                         : req.offset_value;
                    dwell_next         = '0;
                    res.current_offset = offset_next;
                end
                slms_pkg::REQ_TICK:
                begin
                    if (bphase < slms_pkg::BPHASE_W'(2 * slms_pkg::BYTE_BITS))
                    begin
                        if (!bphase[0])
                        begin
                            pins_next[pin_dat] = data_bit;
                            pins_next[pin_shf] = 1'b1;
                        end
                        else
                        begin
                            pins_next[pin_shf] = 1'b0;
                        end
                    end
                    else
                    begin
                        pins_next[pin_lat] =
                            (bphase == slms_pkg::BPHASE_W'(2 * slms_pkg::BYTE_BITS));
                    end

                    if (cfg.auto_scroll && (dwell_reg < slms_pkg::DWELL_MAX))
                        dwell_next = dwell_reg + 1'b1;

                    if (phase_reg == slms_pkg::PHASE_W'(slms_pkg::ROW_SPAN - 1))
                    begin
                        phase_next = '0;
                        if (frame_end)
                        begin
                            scan_row_next  = '0;
                            res.frame_done = 1'b1;
                            if (cfg.auto_scroll && (dwell_next >= need))
                            begin
                                dwell_next = '0;
                                if ((({1'b0, offset_reg} + 1'b1) < {1'b0, cfg.scroll_steps}) &&
                                    (offset_reg < MAX_OFFSET))
                                    offset_next = offset_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            scan_row_next = scan_row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
        res.pins = pins_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MATRIX_ROWS; i++)
                rows_reg[i] <= '0;
            offset_reg   <= '0;
            dwell_reg    <= '0;
            scan_row_reg <= '0;
            phase_reg    <= '0;
            pins_reg     <= '0;
        end
        else
        begin
            if (wr_en)
                rows_reg[wr_idx] <= req.row_bits[CONTENT_BITS-1:0];
            offset_reg   <= offset_next;
            dwell_reg    <= dwell_next;
            scan_row_reg <= scan_row_next;
            phase_reg    <= phase_next;
            pins_reg     <= pins_next;
        end
    end

endmodule

`default_nettype wire
